// ----- rtl/core/msfd_pkg.sv -----
package msfd_pkg;

   localparam int QUEUE_DEPTH = 128;
   localparam int NUM_SERVERS = 4;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SRV_W   = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

   // queue entry: {job id, arrival tick, service time}
   localparam int ENTRY_W = 16 + 16 + 8;

   localparam logic [2:0] KIND_QUEUED   = 3'd0;
   localparam logic [2:0] KIND_REJECTED = 3'd1;
   localparam logic [2:0] KIND_DONE     = 3'd2;
   localparam logic [2:0] KIND_STARTED  = 3'd3;
   localparam logic [2:0] KIND_SUMMARY  = 3'd4;

   typedef logic [2:0] step_type;

   localparam step_type STEP_IDLE    = 3'd0;
   localparam step_type STEP_ARRIVE  = 3'd1;
   localparam step_type STEP_SERVE   = 3'd2;
   localparam step_type STEP_CHECK   = 3'd3;
   localparam step_type STEP_FETCH   = 3'd4;
   localparam step_type STEP_START   = 3'd5;
   localparam step_type STEP_NEXT    = 3'd6;
   localparam step_type STEP_SUMMARY = 3'd7;

   typedef enum logic [2:0] {
      UOP_WAIT,
      UOP_ARRIVE,
      UOP_SERVE,
      UOP_NOP,
      UOP_FETCH,
      UOP_START,
      UOP_SUMMARY
   } uop_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_NOT_LAST,
      COND_EMPTY,
      COND_BUSY
   } cond_type;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      step_type target;
      logic     srv_adv;
      logic     srv_clr;
   } ctrl_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] job_id;
      logic [1:0]  server;
      logic [15:0] tick_time;
      logic [15:0] wait_res;
      logic [7:0]  service_out;
      logic [7:0]  queue_length;
      logic [31:0] wait_sum;
      logic [15:0] job_count;
      logic        last;
   } rsp_type;

   // control store: one word per step
   function automatic ctrl_type msfd_rom(input step_type step);
      ctrl_type c;
      c = '{op: UOP_NOP, cond: COND_NEXT, target: STEP_IDLE, srv_adv: 1'b0, srv_clr: 1'b0};
      unique case (step)
         STEP_IDLE: begin
            c.op = UOP_WAIT;    c.cond = COND_NO_REQ;   c.target = STEP_IDLE;
         end
         STEP_ARRIVE: begin
            c.op = UOP_ARRIVE;  c.cond = COND_NEXT;
         end
         STEP_SERVE: begin
            c.op = UOP_SERVE;   c.cond = COND_NOT_LAST; c.target = STEP_SERVE;
            c.srv_adv = 1'b1;
         end
         STEP_CHECK: begin
            c.op = UOP_NOP;     c.cond = COND_EMPTY;    c.target = STEP_SUMMARY;
         end
         STEP_FETCH: begin
            c.op = UOP_FETCH;   c.cond = COND_BUSY;     c.target = STEP_NEXT;
         end
         STEP_START: begin
            c.op = UOP_START;   c.cond = COND_NEXT;
         end
         STEP_NEXT: begin
            c.op = UOP_NOP;     c.cond = COND_NOT_LAST; c.target = STEP_CHECK;
            c.srv_adv = 1'b1;
         end
         STEP_SUMMARY: begin
            c.op = UOP_SUMMARY; c.cond = COND_ALWAYS;   c.target = STEP_IDLE;
            c.srv_clr = 1'b1;
         end
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/core/multi_server_fifo_dispatch.sv -----
// Multi-server FIFO dispatcher, one tick per request word.
// Request channel (req_): one word per tick; req_arrival marks a new job whose
// service time is req_job_service. Response channel (rsp_): a stream of words,
// in order: arrival queued or rejected, jobs done (server order), jobs started
// (server order, with the wait), then one summary word with rsp_last high.
// A small microprogram sequences the tick: it visits the servers one per cycle,
// unless the receiver stalls, to retire finished jobs, then walks them again
// while jobs wait, reading the job queue RAM (one read port, registered): each
// server visited takes a check, fetch and advance step, with a start step
// between fetch and advance when a job starts.
// req_ready is high only in the idle step that follows the summary word, so
// one tick is worked at a time: the next request word is accepted only once
// the summary word of the last tick sits in the output register.
// When the receiver stalls, the sequencer holds on the step that produces the
// next response word; nothing is dropped.
// Reset (synchronous, active high) empties the queue, frees all servers and
// clears the tick counter, the job id counter and the wait total. The queue
// RAM is not cleared: only entries written since reset are ever read.
module multi_server_fifo_dispatch (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_arrival,
   input  logic [7:0]  req_job_service,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_job_id,
   output logic [1:0]  rsp_server,
   output logic [15:0] rsp_tick_time,
   output logic [15:0] rsp_wait_res,
   output logic [7:0]  rsp_service_out,
   output logic [7:0]  rsp_queue_length,
   output logic [31:0] rsp_wait_sum,
   output logic [15:0] rsp_job_count,
   output logic        rsp_last
);

   localparam int PTR_W   = msfd_pkg::PTR_W;
   localparam int COUNT_W = msfd_pkg::COUNT_W;
   localparam int SRV_W   = msfd_pkg::SRV_W;
   localparam int NSRV    = msfd_pkg::NUM_SERVERS;
   localparam int QDEPTH  = msfd_pkg::QUEUE_DEPTH;

   // sequencer
   msfd_pkg::step_type step_ff, step_in;
   msfd_pkg::ctrl_type ctrl;
   logic [SRV_W-1:0]   srv_ff, srv_in;
   logic               srv_last;

   // latched request word
   logic               arr_ff, arr_in;
   logic [7:0]         svc_ff, svc_in;

   // queue
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               q_full;
   logic               q_empty;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [msfd_pkg::ENTRY_W-1:0] ram_wr_data;
   logic [msfd_pkg::ENTRY_W-1:0] ram_rd_data;
   logic [15:0]        ent_id;
   logic [15:0]        ent_arr;
   logic [7:0]         ent_svc;

   // servers
   logic [NSRV-1:0]    busy_ff, busy_in;
   logic [7:0]         rem_ff [NSRV];
   logic [7:0]         rem_in [NSRV];
   logic [15:0]        job_ff [NSRV];
   logic [15:0]        job_in [NSRV];

   // counters
   logic [15:0]        tick_ff, tick_in;
   logic [15:0]        id_ff, id_in;
   logic [31:0]        wsum_ff, wsum_in;
   logic [15:0]        wait_now;
   logic [32:0]        wsum_add;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   msfd_pkg::rsp_type  rsp_ff, rsp_in;
   msfd_pkg::rsp_type  emit_word;
   logic               emit_req;
   logic               slot_free;
   logic               stall;
   logic               fire;

   assign ctrl      = msfd_pkg::msfd_rom(step_ff);
   assign srv_last  = (srv_ff == SRV_W'(NSRV - 1));
   assign q_full    = (count_ff == COUNT_W'(QDEPTH));
   assign q_empty   = (count_ff == '0);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign stall     = emit_req && !slot_free;
   assign fire      = !stall;
   assign req_ready = (ctrl.op == msfd_pkg::UOP_WAIT);

   assign ent_id   = ram_rd_data[39:24];
   assign ent_arr  = ram_rd_data[23:8];
   assign ent_svc  = ram_rd_data[7:0];
   assign wait_now = tick_ff - ent_arr;
   assign wsum_add = {1'b0, wsum_ff} + {17'd0, wait_now};

   assign ram_wr_data = {id_ff, tick_ff, svc_ff};
   assign ram_wr_en   = (ctrl.op == msfd_pkg::UOP_ARRIVE) && arr_ff && !q_full && fire;
   assign ram_rd_en   = (ctrl.op == msfd_pkg::UOP_FETCH);

   msfd_ram #(
      .WIDTH (msfd_pkg::ENTRY_W),
      .DEPTH (QDEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // next step
   always_comb begin
      step_in = step_ff;
      if (fire) begin
         unique case (ctrl.cond)
            msfd_pkg::COND_NEXT:     step_in = step_ff + 3'd1;
            msfd_pkg::COND_ALWAYS:   step_in = ctrl.target;
            msfd_pkg::COND_NO_REQ:   step_in = req_valid ? step_ff + 3'd1 : ctrl.target;
            msfd_pkg::COND_NOT_LAST: step_in = srv_last ? step_ff + 3'd1 : ctrl.target;
            msfd_pkg::COND_EMPTY:    step_in = q_empty ? ctrl.target : step_ff + 3'd1;
            msfd_pkg::COND_BUSY:     step_in = busy_ff[srv_ff] ? ctrl.target : step_ff + 3'd1;
            default:                 step_in = ctrl.target;
         endcase
      end
   end

   // response word for the current step
   always_comb begin
      emit_req  = 1'b0;
      emit_word = '0;
      emit_word.tick_time = tick_ff;
      unique case (ctrl.op)
         msfd_pkg::UOP_ARRIVE: begin
            emit_req              = arr_ff;
            emit_word.kind        = q_full ? msfd_pkg::KIND_REJECTED : msfd_pkg::KIND_QUEUED;
            emit_word.job_id      = id_ff;
            emit_word.service_out = svc_ff;
         end
         msfd_pkg::UOP_SERVE: begin
            emit_req         = busy_ff[srv_ff] && (rem_ff[srv_ff] == 8'd0);
            emit_word.kind   = msfd_pkg::KIND_DONE;
            emit_word.job_id = job_ff[srv_ff];
            emit_word.server = 2'(srv_ff);
         end
         msfd_pkg::UOP_START: begin
            emit_req           = 1'b1;
            emit_word.kind     = msfd_pkg::KIND_STARTED;
            emit_word.job_id   = ent_id;
            emit_word.server   = 2'(srv_ff);
            emit_word.wait_res = wait_now;
         end
         msfd_pkg::UOP_SUMMARY: begin
            emit_req               = 1'b1;
            emit_word.kind         = msfd_pkg::KIND_SUMMARY;
            emit_word.queue_length = 8'(count_ff);
            emit_word.wait_sum     = wsum_ff;
            emit_word.job_count    = id_ff;
            emit_word.last         = 1'b1;
         end
         default: begin
            emit_req = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      srv_in       = srv_ff;
      arr_in       = arr_ff;
      svc_in       = svc_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      busy_in      = busy_ff;
      rem_in       = rem_ff;
      job_in       = job_ff;
      tick_in      = tick_ff;
      id_in        = id_ff;
      wsum_in      = wsum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (fire) begin
         if (emit_req) begin
            rsp_in       = emit_word;
            rsp_valid_in = 1'b1;
         end
         if (ctrl.srv_adv) begin
            srv_in = srv_last ? '0 : srv_ff + SRV_W'(1);
         end
         if (ctrl.srv_clr) begin
            srv_in = '0;
         end

         unique case (ctrl.op)
            msfd_pkg::UOP_WAIT: begin
               arr_in = req_arrival;
               svc_in = req_job_service;
            end
            msfd_pkg::UOP_ARRIVE: begin
               if (arr_ff) begin
                  id_in = id_ff + 16'd1;
                  if (!q_full) begin
                     tail_in  = (tail_ff == PTR_W'(QDEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
            end
            msfd_pkg::UOP_SERVE: begin
               if (busy_ff[srv_ff]) begin
                  if (rem_ff[srv_ff] == 8'd0) begin
                     busy_in[srv_ff] = 1'b0;
                  end else begin
                     rem_in[srv_ff] = rem_ff[srv_ff] - 8'd1;
                  end
               end
            end
            msfd_pkg::UOP_START: begin
               head_in         = (head_ff == PTR_W'(QDEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
               count_in        = count_ff - COUNT_W'(1);
               busy_in[srv_ff] = 1'b1;
               rem_in[srv_ff]  = ent_svc;
               job_in[srv_ff]  = ent_id;
               wsum_in         = wsum_add[32] ? 32'hFFFF_FFFF : wsum_add[31:0];
            end
            msfd_pkg::UOP_SUMMARY: begin
               tick_in = tick_ff + 16'd1;
            end
            default: begin
               tick_in = tick_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= msfd_pkg::STEP_IDLE;
         srv_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         busy_ff      <= '0;
         tick_ff      <= '0;
         id_ff        <= '0;
         wsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NSRV; i++) begin
            rem_ff[i] <= '0;
            job_ff[i] <= '0;
         end
      end else begin
         step_ff      <= step_in;
         srv_ff       <= srv_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         tick_ff      <= tick_in;
         id_ff        <= id_in;
         wsum_ff      <= wsum_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
         job_ff       <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      arr_ff <= arr_in;
      svc_ff <= svc_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_job_id       = rsp_ff.job_id;
   assign rsp_server       = rsp_ff.server;
   assign rsp_tick_time    = rsp_ff.tick_time;
   assign rsp_wait_res     = rsp_ff.wait_res;
   assign rsp_service_out  = rsp_ff.service_out;
   assign rsp_queue_length = rsp_ff.queue_length;
   assign rsp_wait_sum     = rsp_ff.wait_sum;
   assign rsp_job_count    = rsp_ff.job_count;
   assign rsp_last         = rsp_ff.last;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QDEPTH))
      else $error("queue count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> (head_ff == tail_ff))
      else $error("empty queue with unequal pointers");

   a_start_nonempty: assert property (@(posedge clock) disable iff (reset)
      (step_ff == msfd_pkg::STEP_START) |-> !q_empty)
      else $error("job start from empty queue");

   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_kind == msfd_pkg::KIND_SUMMARY))
      else $error("last flag on non-summary word");
`endif

endmodule

// ----- rtl/core/msfd_ram.sv -----
module msfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
